// ----- hw/rtl/cdq_pkg.sv -----
// Shared types and codes for the circular deque.
`default_nettype none

package cdq_pkg;

  // Operation codes carried on op_i
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_REAR   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;     // capture the accepted beat
    logic exec;     // apply the operation to pointers and store
    logic capture;  // latch RAM read data as the popped value
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_push;
    logic empty;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cdq_ctrl.sv -----
// Control state machine for the circular deque.
`default_nettype none

module cdq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  input  cdq_pkg::dp_status_t dp_st_i,
  output cdq_pkg::cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       pop_ok;

  // successful pop passes through the read state for RAM read data
  assign pop_ok = !dp_st_i.is_push && !dp_st_i.empty;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = pop_ok ? S_READ : S_RESP;
      end
      S_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule

`default_nettype wire

// ----- hw/rtl/cdq_dp.sv -----
// Datapath: pointers, fill count, element store and result registers.
`default_nettype none

module cdq_dp #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdq_pkg::cmd_t       cmd_i,
  output cdq_pkg::dp_status_t dp_st_o,
  input  logic [1:0]          op_i,
  input  logic [WIDTH-1:0]    value_i,
  output logic [WIDTH-1:0]    popped_o,
  output logic [1:0]          status_o,
  output logic [CW-1:0]       count_o
);

  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [1:0]       op_q;
  logic [WIDTH-1:0] value_q;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [WIDTH-1:0] popped_q;
  logic [1:0]       status_q, status_d;
  logic [CW-1:0]    count_q;

  logic             is_push, full, empty;
  logic [AW-1:0]    head_prev, head_next, tail_prev, tail_next;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [WIDTH-1:0] rdata;

  assign is_push = (op_q == cdq_pkg::OP_PUSH_FRONT) || (op_q == cdq_pkg::OP_PUSH_REAR);
  assign full    = (fill_q == FullCnt);
  assign empty   = (fill_q == '0);

  assign dp_st_o.is_push = is_push;
  assign dp_st_o.empty   = empty;

  assign head_prev = (head_q == '0) ? LastIdx : head_q - 1'b1;
  assign head_next = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? LastIdx : tail_q - 1'b1;
  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    status_d = cdq_pkg::ST_OK;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = '0;
    raddr    = head_q;
    if (is_push) begin
      if (full) begin
        status_d = cdq_pkg::ST_FULL;
      end else begin
        we     = cmd_i.exec;
        fill_d = fill_q + 1'b1;
        if (empty) begin
          // first element lands at slot zero
          head_d = '0;
          tail_d = '0;
          waddr  = '0;
        end else if (op_q == cdq_pkg::OP_PUSH_FRONT) begin
          head_d = head_prev;
          waddr  = head_prev;
        end else begin
          tail_d = tail_next;
          waddr  = tail_next;
        end
      end
    end else begin
      if (empty) begin
        status_d = cdq_pkg::ST_EMPTY;
      end else begin
        re     = cmd_i.exec;
        fill_d = fill_q - 1'b1;
        if (op_q == cdq_pkg::OP_POP_FRONT) begin
          raddr  = head_q;
          head_d = head_next;
        end else begin
          raddr  = tail_q;
          tail_d = tail_prev;
        end
        // last element gone: pointers back to zero
        if (fill_q == CW'(1)) begin
          head_d = '0;
          tail_d = '0;
        end
      end
    end
  end

  cdq_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(value_q),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // beat and result payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      popped_q <= '0;
      status_q <= status_d;
      count_q  <= fill_d;
    end else if (cmd_i.capture) begin
      popped_q <= rdata;
    end
  end

  assign popped_o = popped_q;
  assign status_o = status_q;
  assign count_o  = count_q;

endmodule

`default_nettype wire

// ----- hw/rtl/circular_deque.sv -----
// Top level of the circular double-ended queue.
//
// Command channel: start with op_i and value_i is taken at a rising edge
// where start is high and busy is low. op_i selects push front, push rear,
// pop front or pop rear; value_i is ignored for pops.
// Result channel: done_o is high for exactly one cycle with popped_o,
// status_o and count_o valid. The receiver must take the beat in that
// cycle; it cannot stall the block.
// Timing: one beat in flight at a time. Pushes and failed operations pass
// through the exec state and raise done_o in the respond state; successful
// pops also pass through a read state, set by the registered read of the
// element RAM. busy drops the cycle after done_o.
// Status: ok, pop from empty (popped zero, nothing changes) or push to
// full (value dropped, nothing changes). count_o is the element count
// after the operation.
// Reset (rst_ni low, asynchronous) clears pointers, count and controller;
// the store is not cleared, only written slots are ever read.
`default_nettype none

module circular_deque #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              op_i,
  input  logic signed [WIDTH-1:0] value_i,
  output logic                    done_o,
  output logic signed [WIDTH-1:0] popped_o,
  output logic [1:0]              status_o,
  output logic [CW-1:0]           count_o
);

  cdq_pkg::cmd_t       cmd;
  cdq_pkg::dp_status_t dp_st;
  logic [WIDTH-1:0]    popped;

  // sequencing: idle -> exec -> (read) -> respond
  cdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .dp_st_i(dp_st),
    .cmd_o  (cmd)
  );

  // pointers, count, RAM and result registers
  cdq_dp #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .dp_st_o (dp_st),
    .op_i    (op_i),
    .value_i ($unsigned(value_i)),
    .popped_o(popped),
    .status_o(status_o),
    .count_o (count_o)
  );

  assign popped_o = $signed(popped);

endmodule

`default_nettype wire

// ----- hw/rtl/circular_deque_chk.sv -----
// Port-level checker for the circular deque, bound to the top level.
`default_nettype none

module circular_deque_chk #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic signed [WIDTH-1:0] popped_o,
  input logic [1:0]              status_o,
  input logic [CW-1:0]           count_o
);

  // accepted beat keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == cdq_pkg::ST_EMPTY) |-> (count_o == '0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == cdq_pkg::ST_FULL) |-> (count_o == CW'(DEPTH)))
    else $error("full status with count below depth");

  a_err_popped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != cdq_pkg::ST_OK) |-> (popped_o == '0))
    else $error("failed operation returned a value");

  // one result per beat: no strobe in two consecutive cycles
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

endmodule

bind circular_deque circular_deque_chk #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_chk (.*);

`default_nettype wire

// ----- tb/cdq_checker.sv -----
// Deque checker: shadow deque state, expected results and result compare.
`timescale 1ns / 1ps

module cdq_checker #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              op_i,
  input  logic signed [WIDTH-1:0] value_i,
  input  logic                    done_o,
  input  logic signed [WIDTH-1:0] popped_o,
  input  logic [1:0]              status_o,
  input  logic [CW-1:0]           count_o,
  output int                      fail_count_o,
  output int                      outstanding_o
);

  typedef struct packed {
    logic signed [WIDTH-1:0] popped;
    logic [1:0]              status;
    logic [CW-1:0]           count;
  } deque_result_t;

  // Shadow copy of the deque
  logic [WIDTH-1:0] shadow_mem [DEPTH];
  int unsigned      front_idx;
  int unsigned      rear_idx;
  int unsigned      occupancy;

  deque_result_t results_due[$];
  int            mismatches;

  // Apply one operation to the shadow deque and queue the result it gives.
  task automatic model_deque_op(input logic [1:0] op, input logic [WIDTH-1:0] val);
    deque_result_t r;
    r.popped = '0;
    r.status = cdq_pkg::ST_OK;
    if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR) begin
      if (occupancy == DEPTH) begin
        r.status = cdq_pkg::ST_FULL;
      end else begin
        if (occupancy == 0) begin
          front_idx     = 0;
          rear_idx      = 0;
          shadow_mem[0] = val;
        end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
          shadow_mem[front_idx] = val;
        end else begin
          rear_idx = (rear_idx == DEPTH - 1) ? 0 : rear_idx + 1;
          shadow_mem[rear_idx] = val;
        end
        occupancy++;
      end
    end else if (occupancy == 0) begin
      r.status = cdq_pkg::ST_EMPTY;
    end else begin
      if (op == cdq_pkg::OP_POP_FRONT) begin
        r.popped  = shadow_mem[front_idx];
        front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
      end else begin
        r.popped = shadow_mem[rear_idx];
        rear_idx = (rear_idx == 0) ? DEPTH - 1 : rear_idx - 1;
      end
      occupancy--;
      if (occupancy == 0) begin
        front_idx = 0;
        rear_idx  = 0;
      end
    end
    r.count = CW'(occupancy);
    results_due.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_r;
    if (!rst_ni) begin
      front_idx = 0;
      rear_idx  = 0;
      occupancy = 0;
      results_due.delete();
      mismatches    <= 0;
      outstanding_o <= 0;
    end else begin
      // result beat first: it always belongs to an earlier command
      if (done_o) begin
        if (results_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing expected: popped=%0d status=%0d count=%0d",
                     $time, popped_o, status_o, count_o);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = results_due.pop_front();
          if (popped_o !== exp_r.popped || status_o !== exp_r.status ||
              count_o !== exp_r.count) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp popped=%0d status=%0d count=%0d, got %0d %0d %0d",
                       $time, exp_r.popped, exp_r.status, exp_r.count,
                       popped_o, status_o, count_o);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy) model_deque_op(op_i, value_i);
      outstanding_o <= results_due.size();
    end
  end

  assign fail_count_o = mismatches;

endmodule

// ----- tb/tb_circular_deque.sv -----
// Testbench top for the circular deque: clock, reset, command stimulus, verdict.
`timescale 1ns / 1ps

module tb_circular_deque;

  localparam int DEPTH       = 16;
  localparam int WIDTH       = 32;
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int RAND_BEATS  = 1500;
  localparam int CYCLE_LIMIT = 200000;

  logic                    clk_i;
  logic                    rst_ni  = 1'b0;
  logic                    start   = 1'b0;
  logic                    busy;
  logic [1:0]              op_i    = cdq_pkg::OP_PUSH_FRONT;
  logic signed [WIDTH-1:0] value_i = '0;
  logic                    done_o;
  logic signed [WIDTH-1:0] popped_o;
  logic [1:0]              status_o;
  logic [CW-1:0]           count_o;
  int                      fail_count;
  int                      outstanding;
  int                      cycles = 0;

  circular_deque #(.DEPTH(DEPTH), .WIDTH(WIDTH)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .op_i    (op_i),
    .value_i (value_i),
    .done_o  (done_o),
    .popped_o(popped_o),
    .status_o(status_o),
    .count_o (count_o)
  );

  // Checker taps both channels; it holds the expected results, we only drive.
  cdq_checker #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .popped_o     (popped_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one command beat after an idle gap. When the gap is zero start stays
  // high from the previous beat, so back-to-back commands never drop start.
  task automatic send_cmd(input logic [1:0] op, input logic [WIDTH-1:0] val, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    value_i <= val;
    // accepted at the first edge where busy was low
    do @(posedge clk_i); while (busy);
  endtask

  // Mostly full-range random data, with the sign and magnitude extremes mixed in.
  function automatic logic [WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(WIDTH-1){1'b0}}};
      1:       return {1'b0, {(WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int burst_len;
    int push_pct;
    int gap_max;
    int sent;
    logic [1:0] op;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pops, single-element push/pop at both ends, extremes,
    // fill to full with wraparound at the front end, pushes into full.
    send_cmd(cdq_pkg::OP_POP_FRONT, '0, 1);
    send_cmd(cdq_pkg::OP_POP_REAR, '1, 0);
    send_cmd(cdq_pkg::OP_PUSH_FRONT, {1'b1, {(WIDTH-1){1'b0}}}, 0);
    send_cmd(cdq_pkg::OP_POP_FRONT, '0, 2);      // last element out
    send_cmd(cdq_pkg::OP_PUSH_REAR, {1'b0, {(WIDTH-1){1'b1}}}, 0);
    send_cmd(cdq_pkg::OP_POP_REAR, '0, 0);       // last element out via rear
    for (int i = 0; i < DEPTH; i++)
      send_cmd((i % 2) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT,
               (i == 3) ? '1 : (i == 4) ? '0 : pick_value(), $urandom_range(0, 2));
    send_cmd(cdq_pkg::OP_PUSH_FRONT, pick_value(), 0);  // full: dropped
    send_cmd(cdq_pkg::OP_PUSH_REAR, pick_value(), 3);   // full: dropped
    send_cmd(cdq_pkg::OP_POP_FRONT, '0, 0);

    // Random: bursts with a drawn push bias walk the fill level between empty
    // and full; some bursts run with no idle cycles at all.
    sent = 0;
    while (sent < RAND_BEATS) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 20;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      for (int i = 0; i < burst_len && sent < RAND_BEATS; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
        send_cmd(op, pick_value(), $urandom_range(0, gap_max));
        sent++;
      end
    end
    start <= 1'b0;

    // Drain: wait for every expected result, then wait for stray beats.
    do @(posedge clk_i); while (outstanding != 0);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/cdq_dp.sv
hw/rtl/circular_deque.sv
hw/rtl/circular_deque_chk.sv
tb/cdq_checker.sv
tb/tb_circular_deque.sv
